// ----- rtl/multi_timer_expiry_manager_top_macros.svh -----
// Assertion helpers for the files that check their own logic; the top level includes them.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef MULTI_TIMER_EXPIRY_MANAGER_TOP_MACROS_SVH
`define MULTI_TIMER_EXPIRY_MANAGER_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MTEM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MTEM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mtem_pkg.sv -----
package mtem_pkg;

	localparam int NUM_TIMERS    = 16;
	localparam int INTERVAL_BITS = 31;
	localparam int ID_BITS       = 4;

	typedef logic [INTERVAL_BITS-1:0] ival_t;
	typedef logic [ID_BITS-1:0]       tid_t;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SET    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_SET    = 2'd2,
		KIND_EXPIRY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Command broadcast to every slot cell.
	typedef struct packed {
		logic    valid;
		action_t op;
		tid_t    timer_id;
		ival_t   ival;
		logic    single_shot;
	} cmd_t;

	// What a slot cell reports back to the controller.
	typedef struct packed {
		logic grant;
		logic hit;
		logic emit;
		logic emit_last;
		logic token_held;
	} cell_stat_t;

	// An interval of zero behaves as one.
	function automatic ival_t clean_interval(input ival_t raw);
		ival_t v;
		v = raw;
		if (raw == '0) begin
			v = ival_t'(1);
		end
		return v;
	endfunction

endpackage

// ----- rtl/mtem_cell.sv -----
module mtem_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mtem_pkg::tid_t          cell_id,
	input  mtem_pkg::cmd_t          cmd,
	input  logic                    taken_in,
	output logic                    taken_out,
	input  logic                    token_in,
	output logic                    token_out,
	input  logic                    more_in,
	output logic                    more_out,
	output mtem_pkg::cell_stat_t    stat
);

	logic                active_q;
	logic                single_q;
	logic                exp_q;
	logic                token_q;
	mtem_pkg::ival_t     interval_q;
	mtem_pkg::ival_t     remain_q;
	logic                claim;
	logic                hit;
	logic                rem_gt1;

	// A free cell claims an add only when no lower cell is free.
	assign claim     = !active_q && !taken_in;
	assign taken_out = taken_in || !active_q;
	assign hit       = active_q && (cmd.timer_id == cell_id);
	assign rem_gt1   = remain_q > mtem_pkg::ival_t'(1);

	// The scan token only moves on while some higher cell still has an expiry.
	assign token_out = token_q && more_in;
	assign more_out  = exp_q || more_in;

	assign stat.grant      = claim;
	assign stat.hit        = hit;
	assign stat.emit       = token_q && exp_q;
	assign stat.emit_last  = !more_in;
	assign stat.token_held = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			single_q <= 1'b0;
			exp_q    <= 1'b0;
			token_q  <= 1'b0;
		end else begin
			token_q <= token_in;
			if (token_q) begin
				exp_q <= 1'b0;
			end
			if (cmd.valid) begin
				case (cmd.op)
					mtem_pkg::ACT_ADD: begin
						if (claim) begin
							active_q <= 1'b1;
							single_q <= cmd.single_shot;
						end
					end
					mtem_pkg::ACT_REMOVE: begin
						if (hit) begin
							active_q <= 1'b0;
						end
					end
					mtem_pkg::ACT_TICK: begin
						if (active_q && !rem_gt1) begin
							exp_q <= 1'b1;
							if (single_q) begin
								active_q <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid) begin
			case (cmd.op)
				mtem_pkg::ACT_ADD: begin
					if (claim) begin
						interval_q <= cmd.ival;
						remain_q   <= cmd.ival;
					end
				end
				mtem_pkg::ACT_SET: begin
					if (hit) begin
						interval_q <= cmd.ival;
						remain_q   <= cmd.ival;
					end
				end
				mtem_pkg::ACT_TICK: begin
					if (active_q) begin
						if (rem_gt1) begin
							remain_q <= remain_q - mtem_pkg::ival_t'(1);
						end else begin
							remain_q <= interval_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/multi_timer_expiry_manager_top.sv -----
// Add, remove and set interval: the reply beat is registered and appears in the cycle after
// start is taken, busy stays low, and a new action may follow in every cycle.
// Tick: busy while a scan token walks the slot chain one cell per cycle, from the
// lowest slot up to the highest expiring slot (only the lowest if none expires);
// expiry beats follow in ascending slot order, at most one per cycle.
// Reset clears every slot to free and drops any pending beat.
`include "multi_timer_expiry_manager_top_macros.svh"

module multi_timer_expiry_manager_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  timer_id,
	input  logic [30:0] interval,
	input  logic        single_shot,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [3:0]  timer_id_res,
	output logic [1:0]  status,
	output logic        last
);

	localparam int N = mtem_pkg::NUM_TIMERS;

	// The slot state lives in a row of identical cells. Commands are broadcast to
	// all of them. Three neighbor chains tie the row together: a "taken" chain runs
	// upward so that only the lowest free cell claims an add, an "expiry pending"
	// chain runs downward so a cell knows whether any higher slot still expired, and
	// the scan token runs upward one cell per clock after a tick while a higher expiry remains.
	mtem_pkg::cmd_t       cmd;
	logic                 accept;
	logic                 tick_go;
	logic [N-1:0]         taken_out;
	logic [N-1:0]         token_out;
	logic [N-1:0]         more_out;
	mtem_pkg::cell_stat_t stat [N];

	logic                 any_hit;
	logic                 any_emit;
	logic                 emit_last;
	logic                 token_any;
	mtem_pkg::tid_t       grant_id;
	mtem_pkg::tid_t       emit_id;

	logic                 result_valid_q;
	mtem_pkg::kind_t      kind_q;
	mtem_pkg::tid_t       id_q;
	mtem_pkg::status_t    status_q;
	logic                 last_q;

	logic                 valid_d;
	mtem_pkg::kind_t      kind_d;
	mtem_pkg::tid_t       id_d;
	mtem_pkg::status_t    status_d;
	logic                 last_d;

	// An action is taken whenever start is high and no tick scan is in progress.
	assign accept = start && !busy;
	assign busy   = token_any;

	assign cmd.valid       = accept;
	assign cmd.op          = mtem_pkg::action_t'(action);
	assign cmd.timer_id    = timer_id;
	assign cmd.ival        = mtem_pkg::clean_interval(interval);
	assign cmd.single_shot = single_shot;

	// A tick launches the scan token into the lowest cell.
	assign tick_go = accept && (cmd.op == mtem_pkg::ACT_TICK);

	for (genvar i = 0; i < N; i++) begin : g_cell
		mtem_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (mtem_pkg::tid_t'(i)),
			.cmd       (cmd),
			.taken_in  ((i == 0) ? 1'b0 : taken_out[(i == 0) ? 0 : i-1]),
			.taken_out (taken_out[i]),
			.token_in  ((i == 0) ? tick_go : token_out[(i == 0) ? 0 : i-1]),
			.token_out (token_out[i]),
			.more_in   ((i == N-1) ? 1'b0 : more_out[(i == N-1) ? 0 : i+1]),
			.more_out  (more_out[i]),
			.stat      (stat[i])
		);
	end

	// Gather the replies of the cells. At most one cell grants, at most one is
	// addressed and at most one holds the token, so plain OR collection is enough.
	always_comb begin
		any_hit   = 1'b0;
		any_emit  = 1'b0;
		emit_last = 1'b0;
		token_any = 1'b0;
		grant_id  = '0;
		emit_id   = '0;
		for (int i = 0; i < N; i++) begin
			any_hit   = any_hit | stat[i].hit;
			any_emit  = any_emit | stat[i].emit;
			emit_last = emit_last | (stat[i].emit & stat[i].emit_last);
			token_any = token_any | stat[i].token_held;
			grant_id  = grant_id | (stat[i].grant ? mtem_pkg::tid_t'(i) : '0);
			emit_id   = emit_id | (stat[i].emit ? mtem_pkg::tid_t'(i) : '0);
		end
	end

	// Next result beat. Command replies and expiry beats never collide, since a
	// command is only taken while no scan is running.
	always_comb begin
		valid_d  = 1'b0;
		kind_d   = mtem_pkg::KIND_EXPIRY;
		id_d     = emit_id;
		status_d = mtem_pkg::ST_OK;
		last_d   = emit_last;
		if (accept) begin
			last_d = 1'b1;
			case (cmd.op)
				mtem_pkg::ACT_ADD: begin
					valid_d = 1'b1;
					kind_d  = mtem_pkg::KIND_ADD;
					// When no cell is free the chain reports nothing taken-free.
					if (taken_out[N-1]) begin
						id_d = grant_id;
					end else begin
						id_d     = '0;
						status_d = mtem_pkg::ST_FULL;
					end
				end
				mtem_pkg::ACT_REMOVE, mtem_pkg::ACT_SET: begin
					valid_d  = 1'b1;
					kind_d   = (cmd.op == mtem_pkg::ACT_REMOVE) ?
						mtem_pkg::KIND_REMOVE : mtem_pkg::KIND_SET;
					id_d     = timer_id;
					status_d = any_hit ? mtem_pkg::ST_OK : mtem_pkg::ST_NOT_FOUND;
				end
				default: begin
				end
			endcase
		end else if (any_emit) begin
			valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		id_q     <= id_d;
		status_q <= status_d;
		last_q   <= last_d;
	end

	assign result_valid = result_valid_q;
	assign result_kind  = kind_q;
	assign timer_id_res = id_q;
	assign status       = status_q;
	assign last         = last_q;

	// The scan token is never split over two cells.
	`MTEM_ASSERT_ALWAYS(a_token_single, $onehot0(token_out) && !token_out[N-1], "scan token duplicated")

	// Every command other than a tick answers with exactly one final beat.
	`MTEM_ASSERT_NEXT(a_cmd_reply, accept && (cmd.op != mtem_pkg::ACT_TICK), result_valid && last, "command reply missing")

	// Once the scan is over, no expiry is left unreported.
	`MTEM_ASSERT_SAME(a_no_stale_expiry, !busy, !more_out[0], "expiry left after scan")

endmodule
